// File: src/vigenere_alphabet_cipher_assert.svh
// Assertion macros for the cipher block.
// Both forms take a label, the clock, the reset and the property parts.
`ifndef VIGENERE_ALPHABET_CIPHER_ASSERT_SVH
`define VIGENERE_ALPHABET_CIPHER_ASSERT_SVH
`ifndef SYNTHESIS
// Property checked at every clock edge outside reset
`define VAC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition at one edge implies the expression at the next edge
`define VAC_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error(msg);
`else
`define VAC_ASSERT(label, clk, rst, prop, msg)
`define VAC_ASSERT_NEXT(label, clk, rst, cond, expr, msg)
`endif
`endif

// File: src/vac_pkg.sv
`timescale 1ns / 1ps
package vac_pkg;

   // Word field widths
   localparam int CP_W  = 21;
   localparam int SYM_W = 8;

   typedef enum logic [1:0] {
      FN_CLEAR   = 2'd0,
      FN_APPEND  = 2'd1,
      FN_RESTART = 2'd2,
      FN_MESSAGE = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FOREIGN = 2'd1,
      ST_EMPTY   = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   // Register indexes
   localparam logic CSR_ALPHABET = 1'b0;
   localparam logic CSR_DECRYPT  = 1'b1;

   // Alphabet selector codes; the unused code behaves as the full alphabet
   localparam logic [1:0] ALPHA_FULL    = 2'd0;
   localparam logic [1:0] ALPHA_RUSSIAN = 2'd1;
   localparam logic [1:0] ALPHA_ENGLISH = 2'd2;

   // Code points
   localparam logic [CP_W-1:0] CP_SPACE    = 21'h20;
   localparam logic [CP_W-1:0] CP_BANG     = 21'h21;
   localparam logic [CP_W-1:0] CP_TILDE    = 21'h7E;
   localparam logic [CP_W-1:0] CP_LAT_UA   = 21'h41;
   localparam logic [CP_W-1:0] CP_LAT_UZ   = 21'h5A;
   localparam logic [CP_W-1:0] CP_LAT_LA   = 21'h61;
   localparam logic [CP_W-1:0] CP_LAT_LZ   = 21'h7A;
   localparam logic [CP_W-1:0] CP_UPPER_YO = 21'h401;
   localparam logic [CP_W-1:0] CP_UPPER_A  = 21'h410;
   localparam logic [CP_W-1:0] CP_LOWER_A  = 21'h430;
   localparam logic [CP_W-1:0] CP_LOWER_YA = 21'h44F;
   localparam logic [CP_W-1:0] CP_LOWER_YO = 21'h451;
   localparam logic [CP_W-1:0] CP_CASE_OFS = 21'h20;

   // Alphabet sizes
   localparam logic [SYM_W-1:0] ASCII_COUNT = 8'd94;
   localparam logic [SYM_W-1:0] CYR_COUNT   = 8'd33;
   localparam logic [SYM_W-1:0] LATIN_COUNT = 8'd26;
   localparam logic [SYM_W-1:0] FULL_COUNT  = 8'd160;
   localparam logic [SYM_W-1:0] YO_POS      = 8'd6;

   typedef struct packed {
      logic             found;
      logic [SYM_W-1:0] idx;
   } lookup_type;

   // Symbol index of a code point in the selected alphabet
   function automatic lookup_type sym_lookup(input logic [CP_W-1:0] cp,
                                             input logic [1:0] sel);
      lookup_type       res;
      logic             cyr_hit;
      logic             lower;
      logic [5:0]       d;
      logic [5:0]       p;
      res     = '0;
      cyr_hit = 1'b0;
      lower   = 1'b0;
      d       = '0;
      p       = '0;
      // Cyrillic position 0..32, Yo after Ie
      if (cp == CP_UPPER_YO) begin
         cyr_hit = 1'b1;
         p       = 6'(YO_POS);
      end else if (cp == CP_LOWER_YO) begin
         cyr_hit = 1'b1;
         lower   = 1'b1;
         p       = 6'(YO_POS);
      end else if (cp >= CP_UPPER_A && cp < CP_LOWER_A) begin
         cyr_hit = 1'b1;
         d       = 6'(cp - CP_UPPER_A);
         p       = (d < 6'(YO_POS)) ? d : d + 6'd1;
      end else if (cp >= CP_LOWER_A && cp <= CP_LOWER_YA) begin
         cyr_hit = 1'b1;
         lower   = 1'b1;
         d       = 6'(cp - CP_LOWER_A);
         p       = (d < 6'(YO_POS)) ? d : d + 6'd1;
      end
      case (sel)
         ALPHA_RUSSIAN: begin
            res.found = cyr_hit;
            res.idx   = SYM_W'(p);
         end
         ALPHA_ENGLISH: begin
            if (cp >= CP_LAT_UA && cp <= CP_LAT_UZ) begin
               res.found = 1'b1;
               res.idx   = SYM_W'(cp - CP_LAT_UA);
            end else if (cp >= CP_LAT_LA && cp <= CP_LAT_LZ) begin
               res.found = 1'b1;
               res.idx   = SYM_W'(cp - CP_LAT_LA);
            end
         end
         default: begin
            if (cp >= CP_BANG && cp <= CP_TILDE) begin
               res.found = 1'b1;
               res.idx   = SYM_W'(cp - CP_BANG);
            end else if (cyr_hit) begin
               res.found = 1'b1;
               res.idx   = ASCII_COUNT + (lower ? CYR_COUNT : '0) + SYM_W'(p);
            end
         end
      endcase
      return res;
   endfunction

   function automatic logic [SYM_W-1:0] alpha_size(input logic [1:0] sel);
      logic [SYM_W-1:0] n;
      case (sel)
         ALPHA_RUSSIAN: n = CYR_COUNT;
         ALPHA_ENGLISH: n = LATIN_COUNT;
         default:       n = FULL_COUNT;
      endcase
      return n;
   endfunction

   // Remainder by a small modulus: parallel compares against its multiples
   function automatic logic [SYM_W-1:0] mod_by(input logic [SYM_W-1:0] k,
                                               input logic [SYM_W-1:0] n);
      logic [SYM_W+3:0] lim;
      logic [SYM_W-1:0] r;
      r   = k;
      lim = '0;
      for (int j = 1; j <= 9; j++) begin
         lim = (SYM_W+4)'(j) * {4'b0, n};
         if ({4'b0, k} >= lim) r = SYM_W'({4'b0, k} - lim);
      end
      return r;
   endfunction

   function automatic logic [SYM_W-1:0] key_mod(input logic [SYM_W-1:0] k,
                                                input logic [1:0] sel);
      logic [SYM_W-1:0] r;
      case (sel)
         ALPHA_RUSSIAN: r = mod_by(k, CYR_COUNT);
         ALPHA_ENGLISH: r = mod_by(k, LATIN_COUNT);
         default:       r = mod_by(k, FULL_COUNT);
      endcase
      return r;
   endfunction

   function automatic logic [CP_W-1:0] cyr_char(input logic [5:0] p, input logic lower);
      logic [CP_W-1:0] c;
      if (p == 6'(YO_POS)) begin
         c = lower ? CP_LOWER_YO : CP_UPPER_YO;
      end else begin
         c = CP_UPPER_A + CP_W'((p < 6'(YO_POS)) ? p : p - 6'd1);
         if (lower) c = c + CP_CASE_OFS;
      end
      return c;
   endfunction

   // Code point of a symbol index in the selected alphabet
   function automatic logic [CP_W-1:0] sym_char(input logic [SYM_W-1:0] r,
                                                input logic [1:0] sel);
      logic [CP_W-1:0] c;
      case (sel)
         ALPHA_RUSSIAN: c = cyr_char(6'(r), 1'b0);
         ALPHA_ENGLISH: c = CP_LAT_UA + CP_W'(r);
         default: begin
            if (r < ASCII_COUNT)
               c = CP_BANG + CP_W'(r);
            else if (r < ASCII_COUNT + CYR_COUNT)
               c = cyr_char(6'(r - ASCII_COUNT), 1'b0);
            else
               c = cyr_char(6'(r - ASCII_COUNT - CYR_COUNT), 1'b1);
         end
      endcase
      return c;
   endfunction

endpackage

// File: src/vigenere_alphabet_cipher.sv
`timescale 1ns / 1ps
// Vigenere cipher over the full 160-symbol, Russian or English alphabet.
// Input channel req_*: one word per character, req_func selects clear key,
// append key char, restart key position or message char, with its code point.
// Result channel rsp_*: exactly one word per input word, in order: the
// ciphered or passed-through code point (0 for key operations) and a status.
// Register port csr_*: index 0 alphabet select, index 1 decrypt mode; csr_ready
// is always high, and registers are only to be written while the block is idle.
// Results are registered in two register stages: key store read and input
// register, then result register. Throughput: one word per cycle while
// rsp_stall does not hold the pipe; the key store read port and the key
// pointer update each take one word every cycle.
// Reset clears the key count, key position, registers and both valid flags;
// the key store is not cleared and needs no sweep, only written entries are used.
// When the receiver raises rsp_stall with a result waiting, the whole pipe
// holds and req_stall rises in the same cycle; an empty output stage never
// stalls the input.
module vigenere_alphabet_cipher #(
   parameter int KEY_DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_func,
   input  logic [vac_pkg::CP_W-1:0] req_code_point,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [vac_pkg::CP_W-1:0] rsp_out_char,
   output logic [1:0]               rsp_status,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic                     csr_index,
   input  logic [1:0]               csr_wdata
);

   import vac_pkg::*;

`include "vigenere_alphabet_cipher_assert.svh"

   localparam int ADDR_W  = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
   localparam int COUNT_W = $clog2(KEY_DEPTH + 1);

   // Registers
   logic [1:0]        alphabet_ff;
   logic              decrypt_ff;
   logic [COUNT_W-1:0] key_count_ff, key_count_in;
   logic [ADDR_W-1:0] key_pos_ff, key_pos_in;
   logic              s1_valid_ff;
   func_type          s1_func_ff;
   logic [CP_W-1:0]   s1_cp_ff;
   logic [SYM_W-1:0]  s1_idx_ff;
   status_type        s1_status_ff, s1_status_in;
   logic              s1_cipher_ff, s1_cipher_in;
   logic              rsp_valid_ff;
   logic [CP_W-1:0]   rsp_out_char_ff, rsp_out_char_in;
   status_type        rsp_status_ff;

   // Front-end signals
   logic              move;
   logic              accept;
   func_type          func;
   lookup_type        lk;
   logic              blank;
   logic [ADDR_W-1:0] pos_eff;
   logic [COUNT_W-1:0] pos_next;
   logic [ADDR_W-1:0] pos_adv;
   logic              key_wr_en;
   logic [SYM_W-1:0]  key_rd_data;

   // Back-end signals
   logic [SYM_W-1:0]  n_sym;
   logic [SYM_W-1:0]  k_sym;
   logic [SYM_W:0]    sum;
   logic [SYM_W-1:0]  r_sym;

   // Pipe advances unless a finished word is held by the receiver
   assign move      = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !move;
   assign accept    = req_valid && move;
   assign csr_ready = 1'b1;

   assign func  = func_type'(req_func);
   assign lk    = sym_lookup(req_code_point, alphabet_ff);
   assign blank = (req_code_point <= CP_SPACE);

   // Key position in use and the one after it, with wrap
   assign pos_eff  = (COUNT_W'(key_pos_ff) < key_count_ff) ? key_pos_ff : '0;
   assign pos_next = COUNT_W'(pos_eff) + COUNT_W'(1);
   assign pos_adv  = (pos_next >= key_count_ff) ? '0 : pos_next[ADDR_W-1:0];

   // Key bookkeeping and front-end status
   always_comb begin
      key_count_in = key_count_ff;
      key_pos_in   = key_pos_ff;
      key_wr_en    = 1'b0;
      s1_status_in = ST_OK;
      s1_cipher_in = 1'b0;
      case (func)
         FN_CLEAR: begin
            key_count_in = '0;
            key_pos_in   = '0;
         end
         FN_APPEND: begin
            if (!lk.found) begin
               s1_status_in = blank ? ST_OK : ST_FOREIGN;
            end else if (key_count_ff >= COUNT_W'(KEY_DEPTH)) begin
               s1_status_in = ST_FULL;
            end else begin
               key_wr_en    = accept;
               key_count_in = key_count_ff + COUNT_W'(1);
            end
         end
         FN_RESTART: begin
            key_pos_in = '0;
         end
         FN_MESSAGE: begin
            if (!lk.found) begin
               s1_status_in = blank ? ST_OK : ST_FOREIGN;
            end else if (key_count_ff == '0) begin
               s1_status_in = ST_EMPTY;
            end else begin
               s1_cipher_in = 1'b1;
               key_pos_in   = pos_adv;
            end
         end
         default: ;
      endcase
   end

   // Key store
   vac_ram #(
      .WIDTH (SYM_W),
      .DEPTH (KEY_DEPTH)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (key_count_ff[ADDR_W-1:0]),
      .wr_data (lk.idx),
      .rd_en   (move),
      .rd_addr (pos_eff),
      .rd_data (key_rd_data)
   );

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         alphabet_ff <= ALPHA_FULL;
         decrypt_ff  <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ALPHABET: alphabet_ff <= csr_wdata;
            CSR_DECRYPT:  decrypt_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Key count and position
   always_ff @(posedge clock) begin
      if (reset) begin
         key_count_ff <= '0;
         key_pos_ff   <= '0;
      end else if (accept) begin
         key_count_ff <= key_count_in;
         key_pos_ff   <= key_pos_in;
      end
   end

   // Input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (move) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         s1_func_ff   <= func;
         s1_cp_ff     <= req_code_point;
         s1_idx_ff    <= lk.idx;
         s1_status_ff <= s1_status_in;
         s1_cipher_ff <= s1_cipher_in;
      end
   end

   // Modular shift of the symbol by the key index
   assign n_sym = alpha_size(alphabet_ff);
   assign k_sym = key_mod(key_rd_data, alphabet_ff);
   assign sum   = decrypt_ff ? ({1'b0, s1_idx_ff} + {1'b0, n_sym} - {1'b0, k_sym})
                             : ({1'b0, s1_idx_ff} + {1'b0, k_sym});
   assign r_sym = (sum >= {1'b0, n_sym}) ? SYM_W'(sum - {1'b0, n_sym}) : sum[SYM_W-1:0];

   always_comb begin
      if (s1_cipher_ff)
         rsp_out_char_in = sym_char(r_sym, alphabet_ff);
      else if (s1_func_ff == FN_MESSAGE)
         rsp_out_char_in = s1_cp_ff;
      else
         rsp_out_char_in = '0;
   end

   // Result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (move) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         rsp_out_char_ff <= rsp_out_char_in;
         rsp_status_ff   <= s1_status_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_char = rsp_out_char_ff;
   assign rsp_status   = rsp_status_ff;

   // Checks
   `VAC_ASSERT(a_pos_in_range, clock, reset, (key_pos_ff == '0) || (COUNT_W'(key_pos_ff) < key_count_ff), "key position beyond key count")
   `VAC_ASSERT(a_count_bound, clock, reset, key_count_ff <= COUNT_W'(KEY_DEPTH), "key count beyond store depth")
   `VAC_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_valid_ff && rsp_stall && s1_valid_ff, s1_valid_ff, "input stage lost a word under stall")
   `VAC_ASSERT(a_full_on_append, clock, reset, (s1_valid_ff && s1_status_ff == ST_FULL) |-> (s1_func_ff == FN_APPEND), "store full reported for a non-append word")
   `VAC_ASSERT(a_cipher_ok, clock, reset, (s1_valid_ff && s1_cipher_ff) |-> (s1_status_ff == ST_OK), "ciphered word with error status")
   `VAC_ASSERT_NEXT(a_count_step, clock, reset, accept && (func != FN_CLEAR), (key_count_ff == $past(key_count_ff)) || (key_count_ff == $past(key_count_ff) + COUNT_W'(1)), "key count jumped")

endmodule

// File: src/vac_ram.sv
`timescale 1ns / 1ps
module vac_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
